FILE: rtl/cdsm_pkg.sv
// Shared types, constants and helpers for the concentric disk sample map.
package cdsm_pkg;

  // Quotient (angle) width: pi/4 in Q30 fits in 30 bits
  localparam int AW = 30;
  // CORDIC datapath width for x, y and z
  localparam int XW = 33;
  // Default parameter values
  localparam int IN_BITS_DEF = 16;
  localparam int ANGLE_STAGES_DEF = 16;

  // pi/4 and inverse CORDIC gain, both Q30
  localparam logic [AW-1:0] ANG_PI4 = 30'd843314857;
  localparam logic [AW:0] INV_GAIN = 31'sd652032874;

  localparam logic signed [15:0] OUT_MAX = 16'sd32767;

  // atan(2^-i) in Q30, truncated
  localparam logic [AW-1:0] ATAN_TAB [32] = '{
    30'd843314856, 30'd497837829, 30'd263043837, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,
    30'd63,        30'd31,        30'd15,        30'd7,
    30'd3,         30'd1,         30'd0,         30'd0
  };

  // Sideband carried along with each beat
  typedef struct packed {
    logic origin;
    logic swap;
    logic neg;
  } cdsm_tag_t;

  // Round Q30 to Q15 and saturate to +-32767
  function automatic logic signed [15:0] sat_q15(input logic signed [XW-1:0] v);
    logic signed [XW:0] s;
    logic signed [XW-15:0] q;
    s = {v[XW-1], v} + (XW+1)'(16384);
    q = s[XW:15];
    if (q > (XW-14)'(OUT_MAX)) begin
      return OUT_MAX;
    end else if (q < -(XW-14)'(OUT_MAX)) begin
      return -OUT_MAX;
    end
    return q[15:0];
  endfunction

endpackage

FILE: rtl/cdsm_div_cell.sv
// One restoring-division cell: resolves one quotient bit of the angle.
module cdsm_div_cell #(
  parameter int DW = 17,
  parameter int SHIFT = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  cdsm_pkg::cdsm_tag_t                  in_tag,
  input  logic signed [cdsm_pkg::XW-1:0]       in_x,
  input  logic [DW+cdsm_pkg::AW-1:0]           in_rem,
  input  logic [DW-1:0]                        in_den,
  input  logic [cdsm_pkg::AW-1:0]              in_quo,
  output logic                                 out_valid,
  output cdsm_pkg::cdsm_tag_t                  out_tag,
  output logic signed [cdsm_pkg::XW-1:0]       out_x,
  output logic [DW+cdsm_pkg::AW-1:0]           out_rem,
  output logic [DW-1:0]                        out_den,
  output logic [cdsm_pkg::AW-1:0]              out_quo
);
  import cdsm_pkg::*;

  localparam int PW = DW + AW;

  logic [PW-1:0] den_sh;
  logic [PW:0]   diff;
  logic          ge;

  // trial subtract of the shifted divisor
  assign den_sh = PW'(in_den) << SHIFT;
  assign diff   = {1'b0, in_rem} - {1'b0, den_sh};
  assign ge     = ~diff[PW];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_tag <= in_tag;
    out_x   <= in_x;
    out_den <= in_den;
    out_rem <= ge ? diff[PW-1:0] : in_rem;
    out_quo <= {in_quo[AW-2:0], ge};
  end

endmodule

FILE: rtl/cdsm_cordic_cell.sv
// One CORDIC rotation cell with a fixed shift and arctangent.
module cdsm_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  cdsm_pkg::cdsm_tag_t            in_tag,
  input  logic signed [cdsm_pkg::XW-1:0] in_x,
  input  logic signed [cdsm_pkg::XW-1:0] in_y,
  input  logic signed [cdsm_pkg::XW-1:0] in_z,
  output logic                           out_valid,
  output cdsm_pkg::cdsm_tag_t            out_tag,
  output logic signed [cdsm_pkg::XW-1:0] out_x,
  output logic signed [cdsm_pkg::XW-1:0] out_y,
  output logic signed [cdsm_pkg::XW-1:0] out_z
);
  import cdsm_pkg::*;

  localparam logic signed [XW-1:0] ATAN = XW'(ATAN_TAB[STAGE]);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  assign dx = in_y >>> STAGE;
  assign dy = in_x >>> STAGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    out_tag <= in_tag;
    if (!in_z[XW-1]) begin
      out_x <= in_x - dx;
      out_y <= in_y + dy;
      out_z <= in_z - ATAN;
    end else begin
      out_x <= in_x + dx;
      out_y <= in_y - dy;
      out_z <= in_z + ATAN;
    end
  end

endmodule

FILE: rtl/concentric_disk_sample_map.sv
// Top level: concentric square-to-disk map, fully pipelined.
// Takes one point per clock (busy is always low) and returns each mapped
// point with done high for one cycle. Results come out in input order and
// cannot be held off. Each point passes stage A, stage B, the 30-cell angle
// divider (one quotient bit per cell), the CORDIC input register, the
// ANGLE_STAGES CORDIC cells and the output register. Bits of u_first/u_second
// are Q0.IN_BITS fractions; disk_x/disk_y are Q1.15 saturated to +-32767.
module concentric_disk_sample_map #(
  parameter int IN_BITS = cdsm_pkg::IN_BITS_DEF,
  parameter int ANGLE_STAGES = cdsm_pkg::ANGLE_STAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [IN_BITS-1:0]        u_first,
  input  logic [IN_BITS-1:0]        u_second,
  output logic                      done,
  output logic signed [15:0]        disk_x,
  output logic signed [15:0]        disk_y
);
  import cdsm_pkg::*;

  localparam int DW = IN_BITS + 1;
  localparam int PW = DW + AW;
  localparam int LAT = AW + ANGLE_STAGES + 4;

  // remap and branch select
  logic signed [IN_BITS+1:0] a_val;
  logic signed [IN_BITS+1:0] b_val;
  logic [DW-1:0]             a_mag;
  logic [DW-1:0]             b_mag;
  logic                      take_a;

  // stage A registers
  logic                      va;
  cdsm_tag_t                 tag_a;
  logic signed [IN_BITS+1:0] r_a;
  logic [DW-1:0]             den_a;
  logic [DW-1:0]             num_a;

  // stage B registers
  logic                      vb;
  cdsm_tag_t                 tag_b;
  logic signed [XW-1:0]      x0_b;
  logic [PW-1:0]             prod_b;
  logic [DW-1:0]             den_b;
  logic signed [IN_BITS+XW:0] rk;

  // divider chain
  logic                      dv   [0:AW];
  cdsm_tag_t                 dtag [0:AW];
  logic signed [XW-1:0]      dx0  [0:AW];
  logic [PW-1:0]             drem [0:AW];
  logic [DW-1:0]             dden [0:AW];
  logic [AW-1:0]             dquo [0:AW];

  // CORDIC chain
  logic                      cv   [0:ANGLE_STAGES];
  cdsm_tag_t                 ctag [0:ANGLE_STAGES];
  logic signed [XW-1:0]      cx   [0:ANGLE_STAGES];
  logic signed [XW-1:0]      cy   [0:ANGLE_STAGES];
  logic signed [XW-1:0]      cz   [0:ANGLE_STAGES];

  logic signed [15:0]        qx;
  logic signed [15:0]        qy;

  assign busy = 1'b0;

  assign a_val  = $signed({1'b0, u_first, 1'b0}) - $signed((IN_BITS+2)'(1) << IN_BITS);
  assign b_val  = $signed({1'b0, u_second, 1'b0}) - $signed((IN_BITS+2)'(1) << IN_BITS);
  assign a_mag  = a_val[IN_BITS+1] ? DW'(-a_val) : DW'(a_val);
  assign b_mag  = b_val[IN_BITS+1] ? DW'(-b_val) : DW'(b_val);
  assign take_a = a_mag > b_mag;

  // stage A: pick radius and numerator
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= start;
    end
  end

  always_ff @(posedge clk) begin
    tag_a.origin <= (a_val == '0) && (b_val == '0);
    tag_a.swap   <= ~take_a;
    tag_a.neg    <= a_val[IN_BITS+1] ^ b_val[IN_BITS+1];
    r_a          <= take_a ? a_val : b_val;
    den_a        <= take_a ? a_mag : b_mag;
    num_a        <= take_a ? b_mag : a_mag;
  end

  // stage B: angle dividend and scaled radius
  assign rk = r_a * $signed(INV_GAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    tag_b  <= tag_a;
    prod_b <= PW'(num_a) * PW'(ANG_PI4);
    x0_b   <= rk[IN_BITS+XW-1:IN_BITS];
    den_b  <= den_a;
  end

  assign dv[0]   = vb;
  assign dtag[0] = tag_b;
  assign dx0[0]  = x0_b;
  assign drem[0] = prod_b;
  assign dden[0] = den_b;
  assign dquo[0] = '0;

  // divider cells, most significant quotient bit first
  for (genvar k = 0; k < AW; k++) begin : g_div
    cdsm_div_cell #(.DW(DW), .SHIFT(AW-1-k)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(dv[k]), .in_tag(dtag[k]), .in_x(dx0[k]), .in_rem(drem[k]),
      .in_den(dden[k]), .in_quo(dquo[k]),
      .out_valid(dv[k+1]), .out_tag(dtag[k+1]), .out_x(dx0[k+1]),
      .out_rem(drem[k+1]), .out_den(dden[k+1]), .out_quo(dquo[k+1])
    );
  end

  // signed angle into the CORDIC chain
  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= dv[AW];
    end
  end

  always_ff @(posedge clk) begin
    ctag[0] <= dtag[AW];
    cx[0]   <= dx0[AW];
    cy[0]   <= '0;
    cz[0]   <= dtag[AW].neg ? -XW'(dquo[AW]) : XW'(dquo[AW]);
  end

  for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_cordic
    cdsm_cordic_cell #(.STAGE(i)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(cv[i]), .in_tag(ctag[i]), .in_x(cx[i]), .in_y(cy[i]), .in_z(cz[i]),
      .out_valid(cv[i+1]), .out_tag(ctag[i+1]), .out_x(cx[i+1]), .out_y(cy[i+1]),
      .out_z(cz[i+1])
    );
  end

  // output rounding, swap and origin
  assign qx = sat_q15(cx[ANGLE_STAGES]);
  assign qy = sat_q15(cy[ANGLE_STAGES]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[ANGLE_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (ctag[ANGLE_STAGES].origin) begin
      disk_x <= '0;
      disk_y <= '0;
    end else if (ctag[ANGLE_STAGES].swap) begin
      disk_x <= qy;
      disk_y <= qx;
    end else begin
      disk_x <= qx;
      disk_y <= qy;
    end
  end

`ifndef SYNTH
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy asserted");
  a_latency: assert property (@(posedge clk) disable iff (rst) start |-> ##LAT done)
    else $error("result missing at fixed latency");
  a_origin: assert property (@(posedge clk) disable iff (rst)
      start && u_first == (IN_BITS'(1) << (IN_BITS-1))
            && u_second == (IN_BITS'(1) << (IN_BITS-1))
      |-> ##LAT (done && disk_x == 16'sd0 && disk_y == 16'sd0))
    else $error("center point not mapped to origin");
  a_sat: assert property (@(posedge clk) disable iff (rst)
      done |-> (disk_x != -16'sd32768) && (disk_y != -16'sd32768))
    else $error("output outside saturation range");
`endif

endmodule

FILE: dv/concentric_disk_sample_map_test.sv
// Self-checking testbench for the concentric disk sample map.
module concentric_disk_sample_map_test;

  localparam int IN_W = 16;
  localparam int STAGES = 16;
  localparam int LATENCY = 2 + 30 + 1 + STAGES + 1;
  localparam int RANDOM_POINTS = 1850;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } disk_point_t;

  // Tracks expected disk points in input order
  class disk_scoreboard;
    disk_point_t pending[$];
    int errors;

    static function automatic logic signed [63:0] asr(logic signed [63:0] v, int s);
      return v >>> s;
    endfunction

    static function automatic logic signed [15:0] round_q15(logic signed [63:0] v);
      logic signed [63:0] q;
      q = (v + 64'sd16384) >>> 15;
      if (q > 64'sd32767) q = 64'sd32767;
      if (q < -64'sd32767) q = -64'sd32767;
      return q[15:0];
    endfunction

    // Concentric map of one square point
    function void note_point(logic [IN_W-1:0] uf, logic [IN_W-1:0] us);
      logic signed [63:0] a, b, r, num, z, x, y, dx, dy, ma, mb;
      logic signed [63:0] atan_q30[32];
      disk_point_t p;
      atan_q30 = '{64'sd843314856, 64'sd497837829, 64'sd263043837, 64'sd133525158,
        64'sd67021686, 64'sd33543515, 64'sd16775850, 64'sd8388437,
        64'sd4194282, 64'sd2097149, 64'sd1048575, 64'sd524287,
        64'sd262143, 64'sd131071, 64'sd65535, 64'sd32767,
        64'sd16383, 64'sd8191, 64'sd4095, 64'sd2047,
        64'sd1023, 64'sd511, 64'sd255, 64'sd127,
        64'sd63, 64'sd31, 64'sd15, 64'sd7, 64'sd3, 64'sd1, 64'sd0, 64'sd0};
      a = $signed({47'd0, uf, 1'b0}) - (64'sd1 <<< IN_W);
      b = $signed({47'd0, us, 1'b0}) - (64'sd1 <<< IN_W);
      if (a == 0 && b == 0) begin
        p.x = '0;
        p.y = '0;
      end else begin
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        if (ma > mb) begin
          r = a; num = b;
        end else begin
          r = b; num = a;
        end
        z = (num * 64'sd843314857) / r;
        x = asr(r * 64'sd652032874, IN_W);
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
          dx = asr(y, i);
          dy = asr(x, i);
          if (z >= 0) begin
            x -= dx; y += dy; z -= atan_q30[i];
          end else begin
            x += dx; y -= dy; z += atan_q30[i];
          end
        end
        // equal magnitudes fall into the swapped branch
        if (ma > mb) begin
          p.x = round_q15(x); p.y = round_q15(y);
        end else begin
          p.x = round_q15(y); p.y = round_q15(x);
        end
      end
      pending.push_back(p);
    endfunction

    function void check_point(logic signed [15:0] dx, logic signed [15:0] dy);
      disk_point_t p;
      if (pending.size() == 0) begin
        $error("unexpected result beat x=%0d y=%0d", dx, dy);
        errors++;
        return;
      end
      p = pending.pop_front();
      if (dx !== p.x) begin
        $error("disk_x expected %0d actual %0d", p.x, dx);
        errors++;
      end
      if (dy !== p.y) begin
        $error("disk_y expected %0d actual %0d", p.y, dy);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [IN_W-1:0] u_first = 0;
  logic [IN_W-1:0] u_second = 0;
  logic busy, done;
  logic signed [15:0] disk_x, disk_y;
  disk_scoreboard board = new();
  int idle_cycles = 0;

  concentric_disk_sample_map #(.IN_BITS(IN_W), .ANGLE_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .u_first(u_first), .u_second(u_second),
    .done(done), .disk_x(disk_x), .disk_y(disk_y)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Accept results and note inputs at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_point(disk_x, disk_y);
      if (start && !busy) board.note_point(u_first, u_second);
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Hold one point until it is accepted; keep start high across a burst
  task automatic send_point(logic [IN_W-1:0] uf, logic [IN_W-1:0] us, bit hold);
    start <= 1;
    u_first <= uf;
    u_second <= us;
    do @(posedge clk); while (busy);
    if (!hold) start <= 0;
  endtask

  task automatic idle_gap(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  // Pick a coordinate biased toward edges and the center
  function automatic logic [IN_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return IN_W'(16'h8000 + $urandom_range(0, 4) - 2);
      2: return IN_W'($urandom_range(0, 3));
      3: return IN_W'(16'hFFFF - $urandom_range(0, 3));
      default: return IN_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [IN_W-1:0] directed[10];
    int burst;
    int sent;
    logic [IN_W-1:0] c;
    directed = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8001,
      16'h4000, 16'hC000, 16'h0001, 16'hAAAA, 16'h5555};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: origin, corners, diagonals (equal magnitude), axes
    send_point(16'h8000, 16'h8000, 0);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++)
        send_point(directed[2*i], directed[(2*j+1) % 10], 1);
    send_point(16'h4000, 16'hC000, 1);
    send_point(16'hC000, 16'hC000, 0);
    idle_gap(3);

    // Random bursts with random gaps
    sent = 0;
    while (sent < RANDOM_POINTS) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        c = pick_coord();
        if ($urandom_range(0, 5) == 0) send_point(c, c ^ {16{$urandom_range(0, 1) == 1}}, 1);
        else send_point(c, pick_coord(), 1);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 60));
    end
    start <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: concentric_disk_sample_map.f
rtl/cdsm_pkg.sv
rtl/cdsm_div_cell.sv
rtl/cdsm_cordic_cell.sv
rtl/concentric_disk_sample_map.sv
dv/concentric_disk_sample_map_test.sv
